FILE: hw/rtl/sliding_window_dilation_1d_assert.svh
// Assertion macros for the sliding window dilation block.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef SLIDING_WINDOW_DILATION_1D_ASSERT_SVH
`define SLIDING_WINDOW_DILATION_1D_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SWD_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/swd_pkg.sv
// Shared constants, codes and types of the sliding window dilation block.
// No dependencies; every other file of the block but the assertion header imports it.
package swd_pkg;

    localparam int K_MAX          = 31;
    localparam int PIXEL_BITS     = 8;
    localparam int RADIUS_BITS    = 5;
    localparam int CFG_DATA_BITS  = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COUNT_BITS     = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

    // Shift line holds the 2*K_MAX+1 newest samples of the image.
    localparam int TAPS        = 2 * K_MAX + 1;
    localparam int TAP_BITS    = $clog2(TAPS + 1);
    // 4-ary reduction tree: taps plus one pad leaf, padded up to a power of four.
    localparam int TREE_LEVELS = ($clog2(TAPS + 1) + 1) / 2;
    localparam int LEAVES      = 1 << (2 * TREE_LEVELS);
    localparam int NODES       = (LEAVES - 1) / 3;

    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RADIUS       = 2'd0,
        CFG_COMBINE_MODE = 2'd1,
        CFG_PAD_VALUE    = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_MAX = 1'b0,
        MODE_MIN = 1'b1
    } combine_mode_t;

    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius;
        combine_mode_t          mode;
        logic [PIXEL_BITS-1:0]  pad;
    } swd_cfg_t;

    // One classified sample as it travels from the front to the back.
    typedef struct packed {
        logic [PIXEL_BITS-1:0]  pixel;
        logic                   last;
        logic [TAP_BITS-1:0]    pos_tap;     // sample index, saturated at TAPS
        logic                   main;        // a centered result is due
        logic                   flush;       // flushed results follow
        logic [RADIUS_BITS-1:0] flush_start; // lag of the first flushed result
    } swd_cmd_t;

    typedef struct packed {
        logic [QPTR_BITS:0] count;
        logic               full;
        logic               empty;
    } swd_qstat_t;

    // One window evaluation: taps 0..lim take part, pad leaf optional.
    typedef struct packed {
        logic                valid;
        logic [TAP_BITS-1:0] lim;
        logic                pad;
        logic                last;
    } swd_req_t;

endpackage

FILE: hw/rtl/swd_if.sv
// Stream channel interfaces for samples in and results out.
// Depends on swd_pkg for the pixel width.
interface swd_in_if import swd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;
    logic                  last_in;

    modport source (output valid, output pixel_in, output last_in, input ready);
    modport sink   (input valid, input pixel_in, input last_in, output ready);
endinterface

interface swd_out_if import swd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  last_out;

    modport source (output valid, output pixel_out, output last_out, input ready);
    modport sink   (input valid, input pixel_out, input last_out, output ready);
endinterface

FILE: hw/rtl/swd_front.sv
// Front end: accepts sample beats, tracks the position in the image and
// classifies each sample into a command. Depends on swd_pkg and swd_in_if.
module swd_front import swd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    swd_in_if.sink      samples,
    input  swd_cfg_t    cfg,
    input  logic        q_full,
    output logic        push,
    output swd_cmd_t    cmd
);

    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [COUNT_BITS-1:0]  pos;
    logic [RADIUS_BITS-1:0] k;
    logic                   has_main;

    assign samples.ready = !q_full;
    assign push          = samples.valid && !q_full;

    always_comb
    begin
        k = (cfg.radius > RADIUS_BITS'(K_MAX)) ? RADIUS_BITS'(K_MAX) : cfg.radius;
        // index of this sample; the count saturates, so does the index
        pos      = (count_reg == COUNT_LIMIT) ? COUNT_LIMIT - 1'b1 : count_reg;
        has_main = pos >= COUNT_BITS'(k);

        cmd.pixel       = samples.pixel_in;
        cmd.last        = samples.last_in;
        cmd.pos_tap     = (pos >= COUNT_BITS'(TAPS)) ? TAP_BITS'(TAPS) : pos[TAP_BITS-1:0];
        cmd.main        = has_main;
        cmd.flush       = samples.last_in && (!has_main || k != '0);
        // short image: pos < k, so it fits the radius width
        cmd.flush_start = has_main ? k - 1'b1 : pos[RADIUS_BITS-1:0];

        count_next = count_reg;
        if (push)
        begin
            if (samples.last_in)
                count_next = '0;
            else if (count_reg != COUNT_LIMIT)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

FILE: hw/rtl/swd_queue.sv
// Short command queue between front and back end.
// Depends on swd_pkg for the command type and depth.
module swd_queue import swd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  swd_cmd_t   push_cmd,
    input  logic       pop,
    output swd_cmd_t   head,
    output swd_qstat_t stat
);

    swd_cmd_t             slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] ptr);
        return (ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = count_reg == (QPTR_BITS + 1)'(QDEPTH);
    assign stat.empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hw/rtl/swd_seq.sv
// Back end issue sequencer: pops commands, shifts samples into the tap line
// and issues one window request per cycle while adv is high. Depends on swd_pkg.
module swd_seq import swd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  swd_cfg_t              cfg,
    input  swd_cmd_t              head,
    input  swd_qstat_t            qstat,
    input  logic                  adv,
    output logic                  pop,
    output swd_req_t              req,
    output logic [PIXEL_BITS-1:0] taps [TAPS]
);

    logic [PIXEL_BITS-1:0]  taps_reg [TAPS];
    logic                   cur_valid_reg;
    logic                   cur_last_reg;
    logic [TAP_BITS-1:0]    cur_pos_reg;
    logic                   main_pend_reg;
    logic                   flush_pend_reg;
    logic [RADIUS_BITS-1:0] lag_reg;

    logic [RADIUS_BITS-1:0] k;
    logic                   issue_main;
    logic                   issue_flush;
    logic [TAP_BITS-1:0]    hi;
    logic                   final_issue;
    logic                   done_now;

    always_comb
    begin
        k           = (cfg.radius > RADIUS_BITS'(K_MAX)) ? RADIUS_BITS'(K_MAX) : cfg.radius;
        issue_main  = cur_valid_reg && main_pend_reg;
        issue_flush = cur_valid_reg && !main_pend_reg && flush_pend_reg;
        // far end of the window, counted back from the newest tap
        hi = issue_main ? TAP_BITS'(k) + TAP_BITS'(k) : TAP_BITS'(lag_reg) + TAP_BITS'(k);

        req.valid = issue_main || issue_flush;
        req.lim   = (hi < cur_pos_reg) ? hi : cur_pos_reg;
        req.pad   = issue_main ? (hi > cur_pos_reg) : 1'b1;
        req.last  = issue_main ? (cur_last_reg && k == '0) : (lag_reg == '0);

        final_issue = issue_main ? !flush_pend_reg : (lag_reg == '0);
        done_now    = !cur_valid_reg || !(main_pend_reg || flush_pend_reg) || final_issue;
        pop         = adv && done_now && !qstat.empty;
    end

    assign taps = taps_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            taps_reg[0] <= head.pixel;
            for (int j = 1; j < TAPS; j++)
                taps_reg[j] <= taps_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            cur_last_reg   <= 1'b0;
            cur_pos_reg    <= '0;
            main_pend_reg  <= 1'b0;
            flush_pend_reg <= 1'b0;
            lag_reg        <= '0;
        end
        else if (adv)
        begin
            priority if (pop)
            begin
                cur_valid_reg  <= 1'b1;
                cur_last_reg   <= head.last;
                cur_pos_reg    <= head.pos_tap;
                main_pend_reg  <= head.main;
                flush_pend_reg <= head.flush;
                lag_reg        <= head.flush_start;
            end
            else if (done_now)
            begin
                cur_valid_reg  <= 1'b0;
                main_pend_reg  <= 1'b0;
                flush_pend_reg <= 1'b0;
            end
            else if (issue_main)
                main_pend_reg <= 1'b0;
            else if (issue_flush)
                lag_reg <= lag_reg - 1'b1;
        end
    end

endmodule

FILE: hw/rtl/swd_reduce.sv
// Back end reduction: masks the taps into leaves and combines them through
// a registered 4-ary tree into the result beat. Depends on swd_pkg, swd_out_if.
module swd_reduce import swd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  swd_cfg_t              cfg,
    input  swd_req_t              req,
    input  logic [PIXEL_BITS-1:0] taps [TAPS],
    output logic                  adv,
    swd_out_if.source             results
);

    logic [PIXEL_BITS-1:0] tree_reg [NODES + LEAVES];
    logic [PIXEL_BITS-1:0] leaf_next [LEAVES];
    logic [TREE_LEVELS:0]  valid_pipe_reg;
    logic [TREE_LEVELS:0]  last_pipe_reg;
    logic [PIXEL_BITS-1:0] ident;

    function automatic logic [PIXEL_BITS-1:0] pick2(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b,
        input combine_mode_t         mode
    );
        if (mode == MODE_MIN)
            return (a < b) ? a : b;
        return (a > b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick4(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b,
        input logic [PIXEL_BITS-1:0] c,
        input logic [PIXEL_BITS-1:0] d,
        input combine_mode_t         mode
    );
        return pick2(pick2(a, b, mode), pick2(c, d, mode), mode);
    endfunction

    // whole pipeline moves together; hold everything while a result waits
    assign adv = !valid_pipe_reg[TREE_LEVELS] || results.ready;

    assign results.valid     = valid_pipe_reg[TREE_LEVELS];
    assign results.pixel_out = tree_reg[0];
    assign results.last_out  = last_pipe_reg[TREE_LEVELS];

    always_comb
    begin
        ident = (cfg.mode == MODE_MIN) ? '1 : '0;
        for (int j = 0; j < LEAVES; j++)
        begin
            if (j < TAPS)
                leaf_next[j] = (TAP_BITS'(j) <= req.lim) ? taps[j] : ident;
            else if (j == TAPS)
                leaf_next[j] = req.pad ? cfg.pad : ident;
            else
                leaf_next[j] = ident;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NODES; i++)
                tree_reg[i] <= pick4(tree_reg[4*i+1], tree_reg[4*i+2],
                                     tree_reg[4*i+3], tree_reg[4*i+4], cfg.mode);
            for (int j = 0; j < LEAVES; j++)
                tree_reg[NODES+j] <= leaf_next[j];
            last_pipe_reg <= {last_pipe_reg[TREE_LEVELS-1:0], req.last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_pipe_reg <= '0;
        else if (adv)
            valid_pipe_reg <= {valid_pipe_reg[TREE_LEVELS-1:0], req.valid};
    end

endmodule

FILE: hw/rtl/sliding_window_dilation_1d.sv
// Centered running max/min filter over a raster pixel stream. The block takes
// one sample beat per clock while its command queue has room and gives one
// result beat per clock while the output is ready; each result is the maximum
// (or minimum) over 2k+1 samples around the sample k positions back, with the
// pad value standing in, once, for window samples outside the image. A sample
// marked last flushes the pending results, which the issue sequencer sends one
// per cycle while the back end advances, so that sample holds the back end
// while the four-entry command queue keeps taking samples. Each
// result beat passes the queue, issue and leaf registers and three tree levels.
// Configure only while the block is idle.
`include "sliding_window_dilation_1d_assert.svh"

module sliding_window_dilation_1d import swd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    swd_in_if.sink                    samples,
    swd_out_if.source                 results,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [RADIUS_BITS-1:0] radius_reg;
    combine_mode_t          mode_reg;
    logic [PIXEL_BITS-1:0]  pad_reg;
    swd_cfg_t               cfg;

    logic                   push;
    logic                   seq_pop;
    logic                   adv;
    swd_cmd_t               push_cmd;
    swd_cmd_t               head;
    swd_qstat_t             q_stat;
    swd_req_t               req;
    logic [PIXEL_BITS-1:0]  taps [TAPS];
    logic [TAP_BITS-1:0]    span_max;

    assign cfg.radius = radius_reg;
    assign cfg.mode   = mode_reg;
    assign cfg.pad    = pad_reg;

    assign span_max = TAP_BITS'(radius_reg) + TAP_BITS'(radius_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_BITS'(1);
            mode_reg   <= MODE_MAX;
            pad_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIUS:       radius_reg <= cfg_data[RADIUS_BITS-1:0];
                CFG_COMBINE_MODE: mode_reg   <= combine_mode_t'(cfg_data[0]);
                CFG_PAD_VALUE:    pad_reg    <= cfg_data[PIXEL_BITS-1:0];
                default:          ;
            endcase
        end
    end

    swd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .cfg     (cfg),
        .q_full  (q_stat.full),
        .push    (push),
        .cmd     (push_cmd)
    );

    swd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (seq_pop),
        .head     (head),
        .stat     (q_stat)
    );

    swd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .head  (head),
        .qstat (q_stat),
        .adv   (adv),
        .pop   (seq_pop),
        .req   (req),
        .taps  (taps)
    );

    swd_reduce u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .taps    (taps),
        .adv     (adv),
        .results (results)
    );

    `SWD_ASSERT_IMPLIES(a_pop_nonempty, seq_pop, !q_stat.empty, "command pop from empty queue")
    `SWD_ASSERT_IMPLIES(a_queue_bound, 1'b1, q_stat.count <= (QPTR_BITS + 1)'(QDEPTH), "queue overrun")
    `SWD_ASSERT_NEXT(a_full_holds, q_stat.full && !seq_pop, q_stat.full, "full queue lost an entry")
    `SWD_ASSERT_IMPLIES(a_window_span, req.valid, req.lim <= span_max, "window wider than 2k+1")

endmodule
